FILE: rtl/core/kais_pkg.sv
package kais_pkg;

	// Configuration register indexes.
	localparam int CfgIdxW = 1;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_MATRIX_ROWS     = 1'b0,
		CFG_AFFINE_CONSTANT = 1'b1
	} cfg_index_t;

	// Field reduction x^8 + x^4 + x^3 + x + 1, low byte only.
	localparam logic [7:0] GfReduce = 8'h1B;
	localparam logic [7:0] GfTopBit = 8'h80;

	// Reset values give the standard AES S-box.
	localparam logic [63:0] MatrixReset = 64'hF87C3E1F8FC7E3F1;
	localparam logic [7:0]  AffineReset = 8'h63;

	// Multiply by x with reduction.
	function automatic logic [7:0] gf_xtime(input logic [7:0] a);
		logic [7:0] r;
		r = {a[6:0], 1'b0};
		if ((a & GfTopBit) != 8'h00) begin
			r = r ^ GfReduce;
		end
		return r;
	endfunction

	// Shift-and-add multiplication in GF(2^8).
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] sh;
		acc = 8'h00;
		sh  = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				acc = acc ^ sh;
			end
			sh = gf_xtime(sh);
		end
		return acc;
	endfunction

	// Squaring is linear over GF(2); synthesis reduces it to an XOR network.
	function automatic logic [7:0] gf_sq(input logic [7:0] a);
		return gf_mul(a, a);
	endfunction

endpackage

FILE: rtl/core/keyed_affine_inverse_sbox.sv
// Keyed AES-style substitution box. Each request carries one byte, which is
// replaced by its multiplicative inverse in GF(2^8) modulo x^8+x^4+x^3+x+1
// (zero maps to zero) and then passed through an affine map over GF(2):
// output bit i is the parity of matrix row i ANDed with the inverse, XORed
// with bit i of the affine constant. After reset the matrix and constant
// hold the AES values, so the block is the standard AES S-box until they are
// rewritten through the configuration port (index 0: the 64-bit matrix, row
// i in bits 8i+7..8i; index 1: the 8-bit constant). The configuration port
// is always ready and should only be written while no request is in flight.
// The datapath is a five-stage pipeline: the inverse is computed as x^254
// by an addition chain with one GF(2^8) multiplier per stage over four
// stages, and the fifth stage applies the affine map. A request passes
// through stages 1 to 5 in order, the result leaving stage 5, and one
// request is accepted in every cycle while the output side takes results.
// A stall on the output holds the pipeline; empty stages still fill, so the input
// keeps accepting until every stage holds a request.
module keyed_affine_inverse_sbox (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [kais_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [63:0]                    cfg_data,
	// Input request channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     in_byte,
	// Result channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     out_byte
);
	import kais_pkg::*;

	// Configuration registers.
	logic [63:0] matrix_rows_q;
	logic [7:0]  affine_constant_q;

	// Stage valid bits and load enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	// Stage payloads, named after the power of the input byte they hold.
	logic [7:0] x2_s1, x3_s1;
	logic [7:0] x2_s2, x12_s2, x15_s2;
	logic [7:0] x2_s3, x252_s3;
	logic [7:0] inv_s4;
	logic [7:0] out_s5;

	// Combinational stage results.
	logic [7:0] x2_c, x3_c;
	logic [7:0] x12_c, x15_c;
	logic [7:0] x240_c, x252_c;
	logic [7:0] inv_c;
	logic [7:0] aff_c;

	// A stage loads when it is empty or when its contents move on this edge.
	assign en_s5 = !v_s5 || !out_stall;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign in_stall  = !en_s1;
	assign out_valid = v_s5;
	assign out_byte  = out_s5;
	assign cfg_ready = 1'b1;

	// Configuration decoder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_rows_q     <= MatrixReset;
			affine_constant_q <= AffineReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_MATRIX_ROWS:     matrix_rows_q     <= cfg_data;
				CFG_AFFINE_CONSTANT: affine_constant_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Stage 1: x^2 and x^3.
	assign x2_c = gf_sq(in_byte);
	assign x3_c = gf_mul(x2_c, in_byte);

	// Stage 2: x^12 = (x^3)^4, then x^15.
	assign x12_c = gf_sq(gf_sq(x3_s1));
	assign x15_c = gf_mul(x12_c, x3_s1);

	// Stage 3: x^240 = (x^15)^16, then x^252.
	assign x240_c = gf_sq(gf_sq(gf_sq(gf_sq(x15_s2))));
	assign x252_c = gf_mul(x240_c, x12_s2);

	// Stage 4: x^254, the inverse; zero stays zero.
	assign inv_c = gf_mul(x252_s3, x2_s3);

	// Stage 5: affine map, one parity per output bit.
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			aff_c[i] = (^(matrix_rows_q[8*i +: 8] & inv_s4)) ^ affine_constant_q[i];
		end
	end

	// Valid bits travel with the data and clear on reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			x2_s1 <= x2_c;
			x3_s1 <= x3_c;
		end
		if (en_s2) begin
			x2_s2  <= x2_s1;
			x12_s2 <= x12_c;
			x15_s2 <= x15_c;
		end
		if (en_s3) begin
			x2_s3   <= x2_s2;
			x252_s3 <= x252_c;
		end
		if (en_s4) begin
			inv_s4 <= inv_c;
		end
		if (en_s5) begin
			out_s5 <= aff_c;
		end
	end

endmodule

FILE: rtl/core/kais_chk.sv
module kais_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte
);

	// A held result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte))
		else $error("result changed while stalled");

	// With the output side draining, nothing may back up to the input.
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || !out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	// An accepted request appears at the output when the output does not stall meanwhile.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
		##1 !out_stall |=> out_valid)
		else $error("result missing after pipeline latency");

endmodule

bind keyed_affine_inverse_sbox kais_chk u_kais_chk (.*);
